>>> src/mmt_pkg.sv
// Shared constants and types for the transposed integer matrix multiply core.
package mmt_pkg;

  localparam int DATA_W = 32;
  localparam int IDX_W = 5;
  localparam int CFG_W = 6;
  localparam int OP_W = 2;
  localparam int DEFAULT_MAX_SIZE = 32;

  localparam logic [CFG_W-1:0] SIZE_RESET = 6'd32;

  localparam logic [OP_W-1:0] OP_LOAD_A = 2'd0;
  localparam logic [OP_W-1:0] OP_LOAD_B = 2'd1;
  localparam logic [OP_W-1:0] OP_READ = 2'd2;

  // Control from the sequencer to the multiply-accumulate unit.
  typedef struct packed {
    logic clear;
    logic valid;
    logic last;
  } mac_ctl_t;

endpackage

>>> src/mmt_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mmt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> src/mmt_mac.sv
// Shared multiply-accumulate unit: one element pair per cycle, wrapping 32-bit sum.
module mmt_mac (
  input  logic                          clk,
  input  logic                          rst,
  input  mmt_pkg::mac_ctl_t             ctl,
  input  logic [mmt_pkg::DATA_W-1:0]    a,
  input  logic [mmt_pkg::DATA_W-1:0]    b,
  output logic [mmt_pkg::DATA_W-1:0]    acc,
  output logic                          done
);

  logic [mmt_pkg::DATA_W-1:0]   mul_low;
  logic [mmt_pkg::DATA_W-1:0]   prod;
  logic                         prod_valid;
  logic                         prod_last;

  // Only the low word of the product matters, so signedness does not.
  assign mul_low = a * b;

  always_ff @(posedge clk) begin
    prod <= mul_low;
    if (rst) begin
      prod_valid <= 1'b0;
      prod_last <= 1'b0;
      done <= 1'b0;
      acc <= '0;
    end else begin
      prod_valid <= ctl.valid;
      prod_last <= ctl.valid && ctl.last;
      done <= prod_valid && prod_last;
      if (ctl.clear) begin
        acc <= '0;
      end else if (prod_valid) begin
        acc <= acc + prod;
      end
    end
  end

endmodule

>>> src/int32_matrix_multiply_transposed_core.sv
// Top level of the signed 32-bit square matrix multiply core with transposed B store.
//
// Usage: items arrive on the in channel (in_valid/in_ready) with opcode, row, col and
// element_value. A load of A or B takes one transfer and gives no result;
// loads outside the configured size are dropped. A read of C(row, col) walks the row
// of A and the column of B through one shared multiply-accumulate unit, one element
// pair per cycle, over matrix_size elements (capped at MAX_SIZE); the data then passes
// through the RAM read register, the product register, the accumulator and the result
// capture on its way to out_valid. A read outside the size skips the multiply and
// returns product 0 with status 1.
// in_ready is high only while no read is in progress.
// The result sits in an output register (out_valid/out_ready); when the receiver
// stalls, the next result waits inside the core and no new item is taken until it
// moves into the output register. The cfg channel writes matrix_size and is always
// ready; write it only while the core is idle. Reset sets matrix_size to 32, clears the
// sequencer and drops out_valid; store contents are undefined until loaded.
module int32_matrix_multiply_transposed_core #(
  parameter int MAX_SIZE = mmt_pkg::DEFAULT_MAX_SIZE
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [mmt_pkg::CFG_W-1:0]          cfg_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [mmt_pkg::OP_W-1:0]           opcode,
  input  logic [mmt_pkg::IDX_W-1:0]          row,
  input  logic [mmt_pkg::IDX_W-1:0]          col,
  input  logic signed [mmt_pkg::DATA_W-1:0]  element_value,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [mmt_pkg::DATA_W-1:0]  product,
  output logic [mmt_pkg::IDX_W-1:0]          out_row,
  output logic [mmt_pkg::IDX_W-1:0]          out_col,
  output logic                               status
);

  localparam int DEPTH = MAX_SIZE * MAX_SIZE;
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(MAX_SIZE + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN = 2'd1;
  localparam logic [1:0] S_WAIT = 2'd2;
  localparam logic [1:0] S_HOLD = 2'd3;

  logic [1:0]                  state;
  logic [mmt_pkg::CFG_W-1:0]   matrix_size;
  logic [NW-1:0]               n;
  logic [NW-1:0]               k;
  logic                        k_last;
  logic                        in_range;
  logic                        in_xfer;
  logic                        out_load;
  logic                        rd_valid;
  logic                        rd_last;
  logic [mmt_pkg::IDX_W-1:0]   req_row;
  logic [mmt_pkg::IDX_W-1:0]   req_col;
  logic [mmt_pkg::DATA_W-1:0]  res_product;
  logic                        res_status;
  logic [AW-1:0]               wr_addr_a;
  logic [AW-1:0]               wr_addr_b;
  logic [AW-1:0]               rd_addr_a;
  logic [AW-1:0]               rd_addr_b;
  logic [31:0]                 wr_addr_a_full;
  logic [31:0]                 wr_addr_b_full;
  logic [31:0]                 rd_addr_a_full;
  logic [31:0]                 rd_addr_b_full;
  logic [mmt_pkg::DATA_W-1:0]  a_data;
  logic [mmt_pkg::DATA_W-1:0]  b_data;
  logic [mmt_pkg::DATA_W-1:0]  acc;
  logic                        mac_done;
  mmt_pkg::mac_ctl_t           mac_ctl;

  assign cfg_ready = 1'b1;
  assign in_ready = (state == S_IDLE);
  assign in_xfer = in_valid && in_ready;
  assign out_load = (state == S_HOLD) && (!out_valid || out_ready);

  // Sizes above MAX_SIZE saturate.
  assign n = (32'(matrix_size) > 32'(MAX_SIZE)) ? NW'(MAX_SIZE) : NW'(matrix_size);
  assign in_range = (32'(row) < 32'(n)) && (32'(col) < 32'(n));
  assign k_last = (k == n - NW'(1));

  assign wr_addr_a_full = 32'(row) * 32'(MAX_SIZE) + 32'(col);
  assign wr_addr_b_full = 32'(col) * 32'(MAX_SIZE) + 32'(row);
  assign rd_addr_a_full = 32'(req_row) * 32'(MAX_SIZE) + 32'(k);
  assign rd_addr_b_full = 32'(req_col) * 32'(MAX_SIZE) + 32'(k);
  assign wr_addr_a = wr_addr_a_full[AW-1:0];
  assign wr_addr_b = wr_addr_b_full[AW-1:0];
  assign rd_addr_a = rd_addr_a_full[AW-1:0];
  assign rd_addr_b = rd_addr_b_full[AW-1:0];

  mmt_ram #(
    .WIDTH(mmt_pkg::DATA_W),
    .DEPTH(DEPTH),
    .AW(AW)
  ) u_store_a (
    .clk(clk),
    .wr_en(in_xfer && (opcode == mmt_pkg::OP_LOAD_A) && in_range),
    .wr_addr(wr_addr_a),
    .wr_data(element_value),
    .rd_en(state == S_RUN),
    .rd_addr(rd_addr_a),
    .rd_data(a_data)
  );

  mmt_ram #(
    .WIDTH(mmt_pkg::DATA_W),
    .DEPTH(DEPTH),
    .AW(AW)
  ) u_store_b (
    .clk(clk),
    .wr_en(in_xfer && (opcode == mmt_pkg::OP_LOAD_B) && in_range),
    .wr_addr(wr_addr_b),
    .wr_data(element_value),
    .rd_en(state == S_RUN),
    .rd_addr(rd_addr_b),
    .rd_data(b_data)
  );

  assign mac_ctl.clear = in_xfer && (opcode == mmt_pkg::OP_READ) && in_range;
  assign mac_ctl.valid = rd_valid;
  assign mac_ctl.last = rd_last;

  mmt_mac u_mac (
    .clk(clk),
    .rst(rst),
    .ctl(mac_ctl),
    .a(a_data),
    .b(b_data),
    .acc(acc),
    .done(mac_done)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      matrix_size <= mmt_pkg::SIZE_RESET;
      k <= '0;
      rd_valid <= 1'b0;
      rd_last <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        matrix_size <= cfg_data;
      end
      // RAM read data lines up with these in the cycle after issue.
      rd_valid <= (state == S_RUN);
      rd_last <= (state == S_RUN) && k_last;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_xfer && (opcode == mmt_pkg::OP_READ)) begin
            req_row <= row;
            req_col <= col;
            k <= '0;
            if (in_range) begin
              res_status <= 1'b0;
              state <= S_RUN;
            end else begin
              res_product <= '0;
              res_status <= 1'b1;
              state <= S_HOLD;
            end
          end
        end
        S_RUN: begin
          k <= k + NW'(1);
          if (k_last) begin
            state <= S_WAIT;
          end
        end
        S_WAIT: begin
          if (mac_done) begin
            res_product <= acc;
            state <= S_HOLD;
          end
        end
        S_HOLD: begin
          if (out_load) begin
            product <= res_product;
            out_row <= req_row;
            out_col <= req_col;
            status <= res_status;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // The accumulator finishes only while the sequencer waits for it.
  assert property (@(posedge clk) disable iff (rst) mac_done |-> (state == S_WAIT))
    else $error("accumulator finished outside the wait state");

  // The element counter never walks past the effective size.
  assert property (@(posedge clk) disable iff (rst) (state == S_RUN) |-> (k < n))
    else $error("element counter beyond matrix size");

  // An out-of-range read skips the multiply and goes straight to the result.
  assert property (@(posedge clk) disable iff (rst)
    (in_xfer && (opcode == mmt_pkg::OP_READ) && !in_range) |=> (state == S_HOLD))
    else $error("out-of-range read entered the multiply loop");

  // A range error always carries a zero product.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && status) |-> (product == '0))
    else $error("range error with nonzero product");

endmodule
